>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/pku_pkg.sv
//------------------------------------------------------------------------------
// Position Kalman update package
// Widths, register indexes and the variance reset value.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package pku_pkg;
    localparam int POS_W = 48;
    localparam int VAR_W = 48;
    localparam int SIG_W = 32;
    localparam int GAIN_W = 33;
    localparam int DEN_W = 50;
    localparam int AXES = 3;
    localparam int GAIN_BITS = 32;
    localparam int PIPE_LAT = GAIN_BITS + 4;
    localparam int IDX_W = 2;
    localparam logic [VAR_W-1:0] VAR_RESET = 48'd65536;
    localparam logic [IDX_W-1:0] REG_VAR_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_VAR_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_VAR_Z = 2'd2;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
endpackage

>>> rtl/core/pku_axis.sv
//------------------------------------------------------------------------------
// Position Kalman axis pipeline
// One axis: square of sigma, a restoring gain divider at one bit per stage,
// then the correction and posterior variance products in split form.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module pku_axis
    import pku_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [VAR_W-1:0]        i_p,
    input  logic signed [POS_W-1:0] i_prior,
    input  logic signed [POS_W-1:0] i_obs,
    input  logic [SIG_W-1:0]        i_sigma,
    output logic signed [POS_W-1:0] o_est,
    output logic [VAR_W-1:0]        o_var
);
    localparam int NB = GAIN_BITS;
    // Stage 0: square sigma, form difference.
    logic [VAR_W-1:0]        r_s0_p;
    logic signed [POS_W-1:0] r_s0_prior;
    logic [POS_W:0]          r_s0_mag;
    logic                    r_s0_neg;
    logic [2*SIG_W-1:0]      r_s0_sq;
    logic signed [POS_W:0]   n_d;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_p     <= i_p;
            r_s0_prior <= i_prior;
            r_s0_sq    <= i_sigma * i_sigma;
            r_s0_neg   <= n_d[POS_W];
            r_s0_mag   <= n_d[POS_W] ? (POS_W+1)'(-n_d) : (POS_W+1)'(n_d);
        end
    end
    assign n_d = (POS_W+1)'(i_obs) - (POS_W+1)'(i_prior);
    // Divider: NB stages, remainder and quotient.
    logic [DEN_W-1:0]        r_rem [NB+1];
    logic [DEN_W-1:0]        r_den [NB+1];
    logic [NB-1:0]           r_q   [NB+1];
    logic                    r_one [NB+1];
    logic [VAR_W-1:0]        r_p   [NB+1];
    logic signed [POS_W-1:0] r_pr  [NB+1];
    logic [POS_W:0]          r_mg  [NB+1];
    logic                    r_ng  [NB+1];
    logic [DEN_W-1:0]        n_den0;
    assign n_den0 = DEN_W'(r_s0_p) + DEN_W'(r_s0_sq[2*SIG_W-1:16]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(r_s0_p);
            r_den[0] <= n_den0;
            r_q[0]   <= '0;
            r_one[0] <= DEN_W'(r_s0_p) >= n_den0;
            r_p[0]   <= r_s0_p;
            r_pr[0]  <= r_s0_prior;
            r_mg[0]  <= r_s0_mag;
            r_ng[0]  <= r_s0_neg;
        end
    end
    for (genvar k = 0; k < NB; k++) begin : g_div
        logic [DEN_W:0] n_sh;
        logic           n_ge;
        assign n_sh = {r_rem[k], 1'b0};
        assign n_ge = n_sh >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? DEN_W'(n_sh - {1'b0, r_den[k]}) : DEN_W'(n_sh);
                r_q[k+1]   <= {r_q[k][NB-2:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_one[k+1] <= r_one[k];
                r_p[k+1]   <= r_p[k];
                r_pr[k+1]  <= r_pr[k];
                r_mg[k+1]  <= r_mg[k];
                r_ng[k+1]  <= r_ng[k];
            end
        end
    end
    // Product stage: split 49/48-bit operands into a low 32-bit part and a high part.
    logic [GAIN_W-1:0] n_g, n_ng;
    assign n_g  = r_one[NB] ? GAIN_W'(1) << NB : GAIN_W'(r_q[NB]);
    assign n_ng = (GAIN_W'(1) << NB) - n_g;
    logic [GAIN_W+16:0]      r_c_hi, r_v_hi;
    logic [GAIN_W+31:0]      r_c_lo, r_v_lo;
    logic signed [POS_W-1:0] r_m_pr;
    logic                    r_m_ng;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_hi <= r_mg[NB][POS_W:32] * n_g;
            r_c_lo <= r_mg[NB][31:0] * n_g;
            r_v_hi <= r_p[NB][VAR_W-1:32] * n_ng;
            r_v_lo <= r_p[NB][31:0] * n_ng;
            r_m_pr <= r_pr[NB];
            r_m_ng <= r_ng[NB];
        end
    end
    logic [POS_W-1:0] n_corr, n_var;
    assign n_corr = POS_W'(r_c_hi) + POS_W'(r_c_lo[GAIN_W+31:32]);
    assign n_var  = VAR_W'(r_v_hi) + VAR_W'(r_v_lo[GAIN_W+31:32]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_est <= r_m_ng ? r_m_pr - $signed(n_corr) : r_m_pr + $signed(n_corr);
            o_var <= n_var;
        end
    end
endmodule

>>> rtl/core/position_kalman_update.sv
// One item accepted every cycle; the pipeline runs from the edge that takes
// start to the edge that takes o_done. Depth is set by the 32-stage
// restoring gain divider per axis, plus square, divider setup, split-product
// and sum stages. busy is always low; results cannot stall.
// Reset (synchronous, active low) clears the valid line and sets all prior
// variances to 1.0.
//------------------------------------------------------------------------------
// Position Kalman update
// Three-axis scalar Kalman measurement update, fully pipelined.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module position_kalman_update
    import pku_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [VAR_W-1:0]        i_cfg_data,
    input  logic                    i_is_position_kind,
    input  logic [3:0]              i_value_count,
    input  logic signed [POS_W-1:0] i_prior_x,
    input  logic signed [POS_W-1:0] i_prior_y,
    input  logic signed [POS_W-1:0] i_prior_z,
    input  logic signed [POS_W-1:0] i_obs_x,
    input  logic signed [POS_W-1:0] i_obs_y,
    input  logic signed [POS_W-1:0] i_obs_z,
    input  logic [SIG_W-1:0]        i_sigma_x,
    input  logic [SIG_W-1:0]        i_sigma_y,
    input  logic [SIG_W-1:0]        i_sigma_z,
    output logic                    o_done,
    output logic                    o_status,
    output logic signed [POS_W-1:0] o_est_x,
    output logic signed [POS_W-1:0] o_est_y,
    output logic signed [POS_W-1:0] o_est_z,
    output logic [VAR_W-1:0]        o_post_var_x,
    output logic [VAR_W-1:0]        o_post_var_y,
    output logic [VAR_W-1:0]        o_post_var_z
);
    localparam int LAT = PIPE_LAT;
    logic [VAR_W-1:0] r_var [AXES];
    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) r_var[a] <= VAR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VAR_X: r_var[0] <= i_cfg_data;
                REG_VAR_Y: r_var[1] <= i_cfg_data;
                REG_VAR_Z: r_var[2] <= i_cfg_data;
                REG_UNUSED: ;
                default: ;
            endcase
        end
    end
    logic n_bad;
    assign n_bad = !i_is_position_kind || i_value_count != 4'd3 ||
                   r_var[0] == '0 || r_var[1] == '0 || r_var[2] == '0 ||
                   i_sigma_x == '0 || i_sigma_y == '0 || i_sigma_z == '0;
    // Side line carrying valid, status and the pass-through values.
    logic                    r_v   [LAT];
    logic                    r_bad [LAT];
    logic signed [POS_W-1:0] r_ppx [LAT], r_ppy [LAT], r_ppz [LAT];
    logic [VAR_W-1:0]        r_pvx [LAT], r_pvy [LAT], r_pvz [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= start;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_bad[0] <= n_bad;
        r_ppx[0] <= i_prior_x; r_ppy[0] <= i_prior_y; r_ppz[0] <= i_prior_z;
        r_pvx[0] <= r_var[0];  r_pvy[0] <= r_var[1];  r_pvz[0] <= r_var[2];
        for (int k = 1; k < LAT; k++) begin
            r_bad[k] <= r_bad[k-1];
            r_ppx[k] <= r_ppx[k-1]; r_ppy[k] <= r_ppy[k-1]; r_ppz[k] <= r_ppz[k-1];
            r_pvx[k] <= r_pvx[k-1]; r_pvy[k] <= r_pvy[k-1]; r_pvz[k] <= r_pvz[k-1];
        end
    end
    logic signed [POS_W-1:0] w_est [AXES];
    logic [VAR_W-1:0]        w_var [AXES];
    pku_axis u_ax (.i_clk(i_clk), .i_en(1'b1), .i_p(r_var[0]),
        .i_prior(i_prior_x), .i_obs(i_obs_x), .i_sigma(i_sigma_x),
        .o_est(w_est[0]), .o_var(w_var[0]));
    pku_axis u_ay (.i_clk(i_clk), .i_en(1'b1), .i_p(r_var[1]),
        .i_prior(i_prior_y), .i_obs(i_obs_y), .i_sigma(i_sigma_y),
        .o_est(w_est[1]), .o_var(w_var[1]));
    pku_axis u_az (.i_clk(i_clk), .i_en(1'b1), .i_p(r_var[2]),
        .i_prior(i_prior_z), .i_obs(i_obs_z), .i_sigma(i_sigma_z),
        .o_est(w_est[2]), .o_var(w_var[2]));
    logic b;
    assign b = r_bad[LAT-1];
    assign o_done       = r_v[LAT-1];
    assign o_status     = b;
    assign o_est_x      = b ? r_ppx[LAT-1] : w_est[0];
    assign o_est_y      = b ? r_ppy[LAT-1] : w_est[1];
    assign o_est_z      = b ? r_ppz[LAT-1] : w_est[2];
    assign o_post_var_x = b ? r_pvx[LAT-1] : w_var[0];
    assign o_post_var_y = b ? r_pvy[LAT-1] : w_var[1];
    assign o_post_var_z = b ? r_pvz[LAT-1] : w_var[2];

    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, 1'b1, o_done == $past(r_v[LAT-2]), "done lost")
    `ASSERT_IMPL(a_var_bound, i_clk, i_rst_n, o_done && !o_status, o_post_var_x <= r_pvx[LAT-1], "var grew")
    `ASSERT_IMPL(a_bad_pass, i_clk, i_rst_n, o_done && o_status, o_est_x == r_ppx[LAT-1], "pass-through broken")
endmodule
